// File: hw/rtl/sjq_pkg.sv
// ----------------------------------------------------------------------------
// sjq_pkg: shared types and constants for the sorted job queue
// Table depth, derived widths, job entry layout, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sjq_pkg;

  // Table depth (2 .. 256) and the widths that follow from it
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Output fill field width is fixed by the interface
  localparam int FILL_W = 5;

  // One job entry as held in the table
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [15:0] arrival;
    logic [15:0] mem;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // Operation codes
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_FIT    = 2'd1,
    FN_FIND   = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  // Result status codes (code 3 is unused)
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/sjq_ram.sv
// ----------------------------------------------------------------------------
// sjq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sjq_ram #(
  parameter int DATA_W    = 64,
  parameter int NUM_WORDS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [$clog2(NUM_WORDS)-1:0]      waddr,
  input  wire logic [DATA_W-1:0]                 wdata,
  input  wire logic [$clog2(NUM_WORDS)-1:0]      raddr,
  output      logic [DATA_W-1:0]                 rdata
);

  logic [DATA_W-1:0] mem_r [NUM_WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sjq_match.sv
// ----------------------------------------------------------------------------
// sjq_match: shared compare unit
// Tests one table entry against the current request: key order for insert,
// memory fit for find-first-fitting, id equality for find and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module sjq_match import sjq_pkg::*; (
  input  wire func_t       func,
  input  wire logic        sort_mode,
  input  wire job_t        req,
  input  wire logic [15:0] mem_free,
  input  wire job_t        entry,
  output      logic        hit
);

  logic [15:0] new_key;
  logic [15:0] ent_key;

  // Sort key: burst for shortest job first, arrival time otherwise
  assign new_key = sort_mode ? req.arrival   : req.burst;
  assign ent_key = sort_mode ? entry.arrival : entry.burst;

  always_comb begin
    case (func)
      FN_INSERT:           hit = (new_key < ent_key);  // insert lands before this one
      FN_FIT:              hit = (entry.mem <= mem_free);
      FN_FIND, FN_REMOVE:  hit = (entry.id == req.id);
      default:             hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_job_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_job_queue_top: sorted job table with insert, fit, find and remove
// Keeps up to DEPTH jobs in key order in a RAM, scanned by one compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transfer (valid/ready). in_ready is high only
//           while the block is idle; it takes one operation at a time.
//   out_* : one result per operation (valid/ready). The result holds in an
//           output register until the receiver takes it; the block stays
//           busy and takes no new operation while the receiver stalls.
//   cfg_* : sort_mode write, always ready; write it only while idle.
// Sequence per operation (operation transfer to result transfer):
//   insert into a full table : result presented directly, no scan
//   find / find fitting      : scan of the held entries (stops at first hit)
//   insert / remove          : scan, then a shift pass that moves entries one
//                              slot up or down (none for a missing id), then the result
//   is presented. The next operation is taken in the cycle after the result
//   transfer. One table read per cycle through the shared compare unit.
// Reset: table empty, sort_mode 0 (by burst). Table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_job_queue_top import sjq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_sort_mode,
  // operations
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_job_id,
  input  wire logic [15:0] in_burst,
  input  wire logic [15:0] in_arrival_time,
  input  wire logic [15:0] in_mem_need,
  input  wire logic [15:0] in_mem_free,
  // results
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  out_status,
  output      logic [15:0] out_id,
  output      logic [15:0] out_burst,
  output      logic [15:0] out_arrival,
  output      logic [15:0] out_mem,
  output      logic [4:0]  out_fill
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Control state
  state_t             state_r,    state_nxt;
  logic [CNT_W-1:0]   count_r,    count_nxt;
  logic [CNT_W-1:0]   ptr_r,      ptr_nxt;
  logic [CNT_W-1:0]   left_r,     left_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [CNT_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic               sort_mode_r;

  // Payload state
  logic [CNT_W-1:0]   pos_r,      pos_nxt;
  func_t              func_r,     func_nxt;
  job_t               req_r,      req_nxt;
  logic [15:0]        mem_free_r, mem_free_nxt;
  job_t               res_r,      res_nxt;
  status_t            status_r,   status_nxt;

  // Table RAM
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  job_t               ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  job_t               ram_rdata;

  logic               match_hit;
  logic               in_fire;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  assign in_fire = in_valid && in_ready;

  sjq_ram #(
    .DATA_W    (JOB_W),
    .NUM_WORDS (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sjq_match u_match (
    .func      (func_r),
    .sort_mode (sort_mode_r),
    .req       (req_r),
    .mem_free  (mem_free_r),
    .entry     (ram_rdata),
    .hit       (match_hit)
  );

  // Sequencer
  always_comb begin
    logic             issue;
    logic             hit;
    logic             up;
    logic [CNT_W-1:0] scan_pos;
    logic [CNT_W-1:0] dst;

    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    left_nxt     = left_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    pos_nxt      = pos_r;
    func_nxt     = func_r;
    req_nxt      = req_r;
    mem_free_nxt = mem_free_r;
    res_nxt      = res_r;
    status_nxt   = status_r;

    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    ram_raddr = ptr_r[ADDR_W-1:0];

    issue    = (ptr_r < count_r);
    hit      = pend_vld_r && match_hit;
    up       = (func_r == FN_INSERT);
    scan_pos = hit ? pend_idx_r : count_r;
    dst      = up ? (pend_idx_r + CNT_W'(1)) : (pend_idx_r - CNT_W'(1));
    ram_waddr = dst[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt     = func_t'(in_func);
          req_nxt      = '{id: in_job_id, burst: in_burst,
                           arrival: in_arrival_time, mem: in_mem_need};
          mem_free_nxt = in_mem_free;
          if (func_t'(in_func) == FN_INSERT && count_r >= CNT_W'(DEPTH)) begin
            // full table: drop and echo the offered job
            res_nxt    = '{id: in_job_id, burst: in_burst,
                           arrival: in_arrival_time, mem: in_mem_need};
            status_nxt = STAT_FULL;
            state_nxt  = ST_DONE;
          end else begin
            ptr_nxt      = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // read one entry per cycle, compare the one read last cycle
        pend_vld_nxt = issue;
        pend_idx_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
        if (hit || (!pend_vld_r && !issue)) begin
          pend_vld_nxt = 1'b0;
          case (func_r)
            FN_INSERT: begin
              pos_nxt    = scan_pos;
              ptr_nxt    = count_r - CNT_W'(1);
              left_nxt   = count_r - scan_pos;
              res_nxt    = req_r;
              status_nxt = STAT_OK;
              state_nxt  = ST_SHIFT;
            end
            FN_REMOVE: begin
              if (hit) begin
                res_nxt    = ram_rdata;
                status_nxt = STAT_OK;
                pos_nxt    = pend_idx_r;
                ptr_nxt    = pend_idx_r + CNT_W'(1);
                left_nxt   = count_r - CNT_W'(1) - pend_idx_r;
                state_nxt  = ST_SHIFT;
              end else begin
                res_nxt    = '0;
                status_nxt = STAT_NONE;
                state_nxt  = ST_DONE;
              end
            end
            default: begin
              // find by id, find first fitting
              res_nxt    = hit ? ram_rdata : '0;
              status_nxt = hit ? STAT_OK : STAT_NONE;
              state_nxt  = ST_DONE;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // write back the entry read last cycle one slot up or down
        if (pend_vld_r) begin
          ram_we = 1'b1;
        end
        if (left_r != '0) begin
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = ptr_r;
          ptr_nxt      = up ? (ptr_r - CNT_W'(1)) : (ptr_r + CNT_W'(1));
          left_nxt     = left_r - CNT_W'(1);
        end else begin
          pend_vld_nxt = 1'b0;
        end
        if (left_r == '0 && !pend_vld_r) begin
          if (up) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r[ADDR_W-1:0];
            ram_wdata = req_r;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      left_r      <= '0;
      pend_vld_r  <= 1'b0;
      pend_idx_r  <= '0;
      sort_mode_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ptr_r      <= ptr_nxt;
      left_r     <= left_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_idx_r <= pend_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        sort_mode_r <= cfg_sort_mode;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    func_r     <= func_nxt;
    req_r      <= req_nxt;
    mem_free_r <= mem_free_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
  end

  // Ports
  assign cfg_ready   = 1'b1;
  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_DONE);
  assign out_status  = status_r;
  assign out_id      = res_r.id;
  assign out_burst   = res_r.burst;
  assign out_arrival = res_r.arrival;
  assign out_mem     = res_r.mem;
  assign fill_ext    = {{FILL_W{1'b0}}, count_r};
  assign out_fill    = fill_ext[FILL_W-1:0];

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status_r == STAT_FULL) |-> (count_r == CNT_W'(DEPTH)))
    else $error("full status reported with free slots");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pend_vld_r) |-> (pend_idx_r < count_r))
    else $error("scan compared an entry beyond the held entries");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && func_r == FN_REMOVE && left_r == '0 && !pend_vld_r)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove did not decrement the entry count");

endmodule

`default_nettype wire
